// ===== rtl/hsl_pkg.sv =====
// Shared types and constants for the HSL to RGB pixel converter.
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

	typedef struct packed {
		logic [6:0] hue_pct;
		logic [6:0] sat_pct;
		logic [6:0] light_pct;
	} hsl_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} rgb_t;

	localparam logic [6:0] PCT_MAX = 7'd100;
	localparam int NUM_CH = 3;
	localparam int CH_RED = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE = 2;

	localparam logic [8:0] HUE_THIRD = 9'd100;
	localparam logic [8:0] HUE_TWO_THIRDS = 9'd200;
	localparam logic [8:0] RAMP_RISE_END = 9'd50;
	localparam logic [8:0] RAMP_FLAT_END = 9'd150;
	localparam logic [8:0] RAMP_FALL_END = 9'd200;
	localparam logic [5:0] RAMP_DEN = 6'd50;

	// floor(y / 15625) == (y * RECIP_M) >> RECIP_SHIFT for y < 2^22
	localparam logic [22:0] RECIP_M = 23'd4398047;
	localparam int RECIP_SHIFT = 36;
	localparam int LEVEL_DIV_SHIFT = 5;

	function automatic logic [6:0] clamp_pct(input logic [6:0] v);
		return (v > PCT_MAX) ? PCT_MAX : v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hsl_to_rgb_converter_core.sv =====
// Five-stage pipelined HSL to RGB pixel converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts one pixel per clock from hue, saturation and lightness in percent
// (values above 100 clamp to 100) to 8-bit red, green and blue, each the
// truncated 255 times its level. An item is taken whenever start is high;
// busy is always low. The result appears with done after it has passed
// one register stage each for the saturation product, the level terms and
// ramp factors, the ramp products, the scaled sum, and the reciprocal divide.
// done is high for one cycle per item; the receiver cannot stall the block.
module hsl_to_rgb_converter_core
	import hsl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire hsl_t hsl,
	output logic      busy,
	output logic      done,
	output rgb_t      rgb
);

	logic accept;
	assign accept = start && !busy;
	assign busy = 1'b0;

	// stage 1: clamp, l*s, channel hues
	logic [6:0] h_c, s_c, l_c;
	logic [8:0] t_c;
	logic [8:0] hue_c [NUM_CH];

	assign h_c = clamp_pct(hsl.hue_pct);
	assign s_c = clamp_pct(hsl.sat_pct);
	assign l_c = clamp_pct(hsl.light_pct);
	assign t_c = 9'(h_c) * 9'd3;

	always_comb begin
		hue_c[CH_RED] = (t_c > HUE_TWO_THIRDS) ? t_c - HUE_TWO_THIRDS : t_c + HUE_THIRD;
		hue_c[CH_GREEN] = t_c;
		hue_c[CH_BLUE] = (t_c < HUE_THIRD) ? t_c + HUE_TWO_THIRDS : t_c - HUE_THIRD;
	end

	logic        vld_s1;
	logic [6:0]  l_s1, s_s1;
	logic        lo_s1;
	logic [13:0] ls_s1;
	logic [8:0]  hue_s1 [NUM_CH];

	always_ff @(posedge clk) begin
		l_s1 <= l_c;
		s_s1 <= s_c;
		lo_s1 <= (l_c < 7'd50);
		ls_s1 <= 14'(l_c) * 14'(s_c);
		for (int i = 0; i < NUM_CH; i++) begin
			hue_s1[i] <= hue_c[i];
		end
	end

	// stage 2: v1, d = v2 - v1, ramp factor per channel
	logic [13:0] l100, s100, v1_c, d_c;
	logic [5:0]  f_c [NUM_CH];
	logic [8:0]  fall_c [NUM_CH];

	assign l100 = 14'(l_s1) * 14'd100;
	assign s100 = 14'(s_s1) * 14'd100;

	always_comb begin
		if (lo_s1) begin
			v1_c = l100 - ls_s1;
			d_c = {ls_s1[12:0], 1'b0};
		end else begin
			v1_c = l100 - s100 + ls_s1;
			d_c = {s100[12:0], 1'b0} - {ls_s1[12:0], 1'b0};
		end
		for (int i = 0; i < NUM_CH; i++) begin
			fall_c[i] = RAMP_FALL_END - hue_s1[i];
			if (hue_s1[i] < RAMP_RISE_END) begin
				f_c[i] = hue_s1[i][5:0];
			end else if (hue_s1[i] < RAMP_FLAT_END) begin
				f_c[i] = RAMP_DEN;
			end else if (hue_s1[i] < RAMP_FALL_END) begin
				f_c[i] = fall_c[i][5:0];
			end else begin
				f_c[i] = '0;
			end
		end
	end

	logic        vld_s2;
	logic [13:0] v1_s2, d_s2;
	logic [5:0]  f_s2 [NUM_CH];

	always_ff @(posedge clk) begin
		v1_s2 <= v1_c;
		d_s2 <= d_c;
		for (int i = 0; i < NUM_CH; i++) begin
			f_s2[i] <= f_c[i];
		end
	end

	// stage 3: ramp products
	logic        vld_s3;
	logic [18:0] base_s3;
	logic [18:0] prod_s3 [NUM_CH];

	always_ff @(posedge clk) begin
		base_s3 <= 19'(v1_s2) * 19'(RAMP_DEN);
		for (int i = 0; i < NUM_CH; i++) begin
			prod_s3[i] <= 19'(d_s2) * 19'(f_s2[i]);
		end
	end

	// stage 4: numerator times 255
	logic [18:0] num_c [NUM_CH];
	logic        vld_s4;
	logic [26:0] x_s4 [NUM_CH];

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			num_c[i] = base_s3 + prod_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			x_s4[i] <= {num_c[i], 8'b0} - 27'(num_c[i]);
		end
	end

	// stage 5: divide by 500000 via shift and reciprocal
	logic [44:0] q_c [NUM_CH];
	logic        vld_s5;
	rgb_t        rgb_s5;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			q_c[i] = 45'(x_s4[i][26:LEVEL_DIV_SHIFT]) * 45'(RECIP_M);
		end
	end

	always_ff @(posedge clk) begin
		rgb_s5.red_out <= q_c[CH_RED][RECIP_SHIFT +: 8];
		rgb_s5.green_out <= q_c[CH_GREEN][RECIP_SHIFT +: 8];
		rgb_s5.blue_out <= q_c[CH_BLUE][RECIP_SHIFT +: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign done = vld_s5;
	assign rgb = rgb_s5;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("accepted item did not complete after five cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1, 4))
		else $error("done without an item accepted five cycles earlier");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hsl.sat_pct == 7'd0) |-> ##5
		(rgb.red_out == rgb.green_out && rgb.green_out == rgb.blue_out))
		else $error("zero saturation gave unequal channels");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hsl.light_pct == 7'd0) |-> ##5
		(rgb.red_out == 8'd0 && rgb.green_out == 8'd0 && rgb.blue_out == 8'd0))
		else $error("zero lightness gave a nonzero channel");

endmodule

`default_nettype wire
